// ----- rtl/core/mu8d_pkg.sv -----
// Package for the modified UTF-8 to UTF-8 decoder.
// Holds the result record type, code point constants and the UTF-8 encoder.
// No dependencies.
`default_nettype none

package mu8d_pkg;

  localparam int QDepth = 4;

  localparam logic [20:0] CpReplacement = 21'h00FFFD;
  localparam logic [20:0] CpSuppBase    = 21'h010000;
  localparam logic [5:0]  SurrHighTag   = 6'b110110;  // 0xD800..0xDBFF
  localparam logic [5:0]  SurrLowTag    = 6'b110111;  // 0xDC00..0xDFFF

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  char_length;
    logic        malformed;
    logic        end_of_string;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [31:0] char_bytes;
    logic [2:0]  char_length;
  } enc_t;

  // Shortest-form UTF-8 of a code point, first byte in the low byte.
  function automatic enc_t encode_cp(input logic [20:0] cp);
    enc_t e;
    if (cp < 21'h80) begin
      e.char_bytes  = {24'd0, 1'b0, cp[6:0]};
      e.char_length = 3'd1;
    end else if (cp < 21'h800) begin
      e.char_bytes  = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      e.char_length = 3'd2;
    end else if (cp < 21'h10000) begin
      e.char_bytes  = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      e.char_length = 3'd3;
    end else begin
      e.char_bytes  = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
      e.char_length = 3'd4;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/modified_utf8_to_utf8_decoder.sv -----
// Top level of the modified UTF-8 to standard UTF-8 decoder.
// Decodes one byte per cycle while byte_stall is low into a small result queue; uses mu8d_pkg.
// Single module; no submodules.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   bytes   | byte_valid, byte_stall | in_byte, last_byte
//   chars   | char_valid, char_stall | char_bytes, char_length, malformed,
//           |                        | end_of_string, last_of_run
//
// Each accepted byte is decoded in the cycle it is accepted; its zero, one or
// two results are registered into a four-entry result queue, read from its head.
// A byte is taken every cycle while the queue holds at most two results, so
// the sustained rate is one byte per cycle when results drain as they come.
// byte_stall comes from the registered queue count only, not from char_stall.
// Synchronous reset clears the decoder state and empties the queue.
`default_nettype none

module modified_utf8_to_utf8_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        last_byte,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [31:0]      char_bytes,
  output logic [2:0]       char_length,
  output logic             malformed,
  output logic             end_of_string,
  output logic             last_of_run
);

  localparam int PtrW = $clog2(mu8d_pkg::QDepth);
  localparam int CntW = $clog2(mu8d_pkg::QDepth + 1);

  // Decoder state.
  logic [1:0]  bytes_expected, bytes_expected_next;
  logic [1:0]  sequence_length, sequence_length_next;
  logic [15:0] code_accumulator, code_accumulator_next;
  logic        high_pending, high_pending_next;
  logic [9:0]  high_offset, high_offset_next;
  logic        error_seen, error_seen_next;

  // Result queue.
  mu8d_pkg::res_t q [mu8d_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  logic        accept, pop;
  logic [15:0] acc_shift;
  logic        is_high, is_low;
  logic [20:0] pair_cp;
  logic [20:0] cp [2];
  logic [1:0]  n_res;
  logic        bad, empty_res;
  mu8d_pkg::res_t res [2];
  mu8d_pkg::enc_t enc [2];

  assign byte_stall = count > CntW'(mu8d_pkg::QDepth - 2);
  assign accept     = byte_valid && !byte_stall;
  assign char_valid = count != '0;
  assign pop        = char_valid && !char_stall;

  assign acc_shift = {code_accumulator[9:0], in_byte[5:0]};
  assign is_high   = acc_shift[15:10] == mu8d_pkg::SurrHighTag;
  assign is_low    = acc_shift[15:10] == mu8d_pkg::SurrLowTag;
  assign pair_cp   = mu8d_pkg::CpSuppBase + {1'b0, high_offset, acc_shift[9:0]};

  always_comb begin
    bytes_expected_next   = bytes_expected;
    sequence_length_next  = sequence_length;
    code_accumulator_next = code_accumulator;
    high_pending_next     = high_pending;
    high_offset_next      = high_offset;
    error_seen_next       = error_seen;
    bad   = 1'b0;
    n_res = 2'd0;
    cp[0] = '0;
    cp[1] = '0;

    if (error_seen) begin
      // Dropping bytes until the end of the string.
    end else if (bytes_expected != 2'd0) begin
      if (in_byte[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        code_accumulator_next = acc_shift;
        bytes_expected_next   = bytes_expected - 2'd1;
        if (bytes_expected == 2'd1) begin
          if (sequence_length != 2'd3) begin
            cp[0] = {5'd0, acc_shift};
            n_res = 2'd1;
          end else if (high_pending && is_low) begin
            cp[0] = pair_cp;
            n_res = 2'd1;
            high_pending_next = 1'b0;
          end else begin
            if (high_pending) begin
              cp[0] = mu8d_pkg::CpReplacement;
              n_res = 2'd1;
              high_pending_next = 1'b0;
            end
            if (is_high) begin
              high_pending_next = 1'b1;
              high_offset_next  = acc_shift[9:0];
            end else begin
              cp[n_res[0]] = is_low ? mu8d_pkg::CpReplacement : {5'd0, acc_shift};
              n_res = n_res + 2'd1;
            end
          end
        end
      end
    end else if (in_byte == 8'h00) begin
      bad = 1'b1;
    end else if (!in_byte[7]) begin
      if (high_pending) begin
        cp[0] = mu8d_pkg::CpReplacement;
        n_res = 2'd1;
        high_pending_next = 1'b0;
      end
      cp[n_res[0]] = {13'd0, in_byte};
      n_res = n_res + 2'd1;
    end else if (in_byte[7:5] == 3'b110) begin
      if (high_pending) begin
        cp[0] = mu8d_pkg::CpReplacement;
        n_res = 2'd1;
        high_pending_next = 1'b0;
      end
      code_accumulator_next = {11'd0, in_byte[4:0]};
      bytes_expected_next   = 2'd1;
      sequence_length_next  = 2'd2;
    end else if (in_byte[7:4] == 4'b1110) begin
      code_accumulator_next = {12'd0, in_byte[3:0]};
      bytes_expected_next   = 2'd2;
      sequence_length_next  = 2'd3;
    end else begin
      bad = 1'b1;
    end

    if (!bad && !error_seen && last_byte) begin
      if (bytes_expected_next != 2'd0) begin
        bad = 1'b1;
      end else if (high_pending_next && n_res != 2'd2) begin
        cp[n_res[0]] = mu8d_pkg::CpReplacement;
        n_res = n_res + 2'd1;
        high_pending_next = 1'b0;
      end
    end

    empty_res = 1'b0;
    if (bad) begin
      n_res = 2'd1;
      empty_res = 1'b1;
      error_seen_next     = 1'b1;
      high_pending_next   = 1'b0;
      bytes_expected_next = 2'd0;
    end else if (last_byte && n_res == 2'd0) begin
      n_res = 2'd1;
      empty_res = 1'b1;
    end

    if (last_byte) begin
      bytes_expected_next   = '0;
      sequence_length_next  = '0;
      code_accumulator_next = '0;
      high_pending_next     = 1'b0;
      high_offset_next      = '0;
      error_seen_next       = 1'b0;
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      enc[k] = mu8d_pkg::encode_cp(cp[k]);
      res[k].char_bytes    = enc[k].char_bytes;
      res[k].char_length   = enc[k].char_length;
      res[k].malformed     = bad;
      res[k].last_of_run   = (n_res == 2'(k + 1));
      res[k].end_of_string = last_byte && (n_res == 2'(k + 1));
    end
    if (empty_res) begin
      res[0].char_bytes  = '0;
      res[0].char_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected   <= '0;
      sequence_length  <= '0;
      code_accumulator <= '0;
      high_pending     <= 1'b0;
      high_offset      <= '0;
      error_seen       <= 1'b0;
    end else if (accept) begin
      bytes_expected   <= bytes_expected_next;
      sequence_length  <= sequence_length_next;
      code_accumulator <= code_accumulator_next;
      high_pending     <= high_pending_next;
      high_offset      <= high_offset_next;
      error_seen       <= error_seen_next;
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      q[wr_ptr] <= res[0];
    end
    if (accept && n_res == 2'd2) begin
      q[wr_ptr + PtrW'(1)] <= res[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (accept ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  assign char_bytes    = q[rd_ptr].char_bytes;
  assign char_length   = q[rd_ptr].char_length;
  assign malformed     = q[rd_ptr].malformed;
  assign end_of_string = q[rd_ptr].end_of_string;
  assign last_of_run   = q[rd_ptr].last_of_run;

  // The queue never overfills, since a byte is taken only with room for two results.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(mu8d_pkg::QDepth))
    else $error("result queue count exceeds its depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!accept && !pop) |=> $stable(count))
    else $error("result queue count changed without a transaction");

  a_malformed_empty: assert property (@(posedge clk) disable iff (rst)
    (char_valid && malformed) |-> (char_length == 3'd0))
    else $error("malformed result carries character bytes");

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && end_of_string) |-> last_of_run)
    else $error("end of string flagged on a result that is not last of its run");

endmodule

`default_nettype wire
